@@ design/assert_macros.svh @@
// assertion macros for the color statistics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/ics_pkg.sv @@
// package: types and constants of the color statistics block
package ics_pkg;
    localparam int unsigned MaxSide       = 4096;
    localparam int unsigned TargetSamples = 10000;
    localparam int unsigned GrayTolerance = 2;
    localparam int unsigned NumChan       = 5;
    localparam int unsigned CntW          = 25;

    // floor(size / TargetSamples) as ((size >> 4) * StrideRecip) >> StrideShift,
    // exact for every size up to MaxSide * MaxSide (10000 = 16 * 625)
    localparam int unsigned StrideRecip = 1717987;
    localparam int unsigned StrideShift = 30;

    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [2:0] channel_select;
        logic [7:0] bin_index;
    } t_in_beat;

    typedef struct packed {
        logic            kind;
        logic [2:0]      channel;
        logic [7:0]      min_value;
        logic [7:0]      max_value;
        logic [15:0]     mean_q8;
        logic [CntW-1:0] bin_count;
        logic [CntW-1:0] pixel_count;
        logic            all_opaque;
        logic            any_transparency;
        logic            single_color;
        logic            rgb_near_equal;
        logic            last;
    } t_out_beat;
endpackage

@@ design/image_color_statistics_unit.sv @@
// top level: histogram and min/max/mean statistics over rgba pixels
//
//  beat      | direction | handshake
//  ----------+-----------+-------------------------------------
//  input     | in        | i_in_valid / o_in_stall, i_in_data
//  result    | out       | o_out_valid / i_out_stall, o_out_data
//  config    | in        | i_cfg_we, i_cfg_index, i_cfg_data
//
// pixel beat: a stride state, then a read and a write-back state per channel
//   on the single-port bin memory; a dropped pixel ends after the stride state
// read beat: the bin count is registered from S_BIN once the output can take it
// finish beat: per channel, a 41-step mean divider, a closing state and a state
//   to load the result; five results in all
// reset clears control state; then a clearing pass sweeps the 1280-word bin
//   memory, during which no input beat is taken; clear beat repeats the pass
// stalls on the output hold the result register; input is stalled until taken
`include "assert_macros.svh"
module image_color_statistics_unit import ics_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_WR   = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_OUT  = 8'b0010_0000,
        S_BIN  = 8'b0100_0000,
        S_STR  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [12:0] r_width, r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) r_width <= i_cfg_data;
            else r_height <= i_cfg_data;
        end
    end

    // image size and stride (stride by reciprocal multiplication in state S_STR)
    logic [12:0] w_c, h_c;
    assign w_c = (r_width  > 13'(MaxSide)) ? 13'(MaxSide) : r_width;
    assign h_c = (r_height > 13'(MaxSide)) ? 13'(MaxSide) : r_height;
    logic [25:0] r_size;
    always_ff @(posedge i_clk) r_size <= 26'(w_c) * 26'(h_c);

    // size is at most 2^24, so size >> 4 fits in 21 bits
    logic [41:0] stride_prod;
    logic [11:0] stride_q;
    assign stride_prod = {21'd0, r_size[24:4]} * 42'(StrideRecip);
    assign stride_q    = 12'(stride_prod >> StrideShift);

    // bin memory: 5 x 256 bins, one port
    logic [CntW-1:0] mem [0:1279];
    logic [10:0] mem_addr;
    logic        mem_we;
    logic [CntW-1:0] mem_wdata, r_mem_q;
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_mem_q <= mem[mem_addr];
    end

    // statistics registers
    logic [7:0]  r_min [NumChan];
    logic [7:0]  r_max [NumChan];
    logic [31:0] r_sum [NumChan];
    logic [CntW-1:0] r_pix, r_cnt_dn;
    logic r_gray;

    t_in_beat  r_item;
    logic [7:0] r_val [NumChan];
    logic [2:0] r_ch;
    logic [10:0] r_clr;
    logic [7:0] r_luma;
    logic [25:0] r_stride;
    t_out_beat r_out, n_out;
    logic r_out_v, n_out_v;
    logic out_load;

    // shared divider: restoring, one bit a cycle
    logic [40:0] r_num;
    logic [25:0] r_den;
    logic [25:0] r_rem;
    logic [5:0]  r_dcnt;
    logic [26:0] d_trial;
    assign d_trial = {r_rem, r_num[40]} - {1'b0, r_den};

    logic accept;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    logic any;
    assign any = (r_pix != '0);

    // result register loads when it is empty or being taken
    assign out_load = ((r_state == S_OUT) || (r_state == S_BIN)) && (!r_out_v || !i_out_stall);
    assign n_out_v  = out_load || (r_out_v && i_out_stall);

    always_comb begin
        n_out = '0;
        if (r_state == S_BIN) begin
            n_out.kind        = 1'b1;
            n_out.channel     = r_item.channel_select;
            n_out.bin_count   = (r_item.channel_select < 3'd5) ? r_mem_q : '0;
            n_out.pixel_count = r_pix;
            n_out.last        = 1'b1;
        end else if (r_state == S_OUT) begin
            n_out.kind             = 1'b0;
            n_out.channel          = r_ch;
            n_out.min_value        = r_min[r_ch];
            n_out.max_value        = r_max[r_ch];
            n_out.mean_q8          = any ? r_num[15:0] : 16'd0;
            n_out.pixel_count      = r_pix;
            n_out.all_opaque       = any && (r_min[3] == 8'hFF);
            n_out.any_transparency = any && (r_min[3] != 8'hFF);
            n_out.single_color     = any && (r_min[0] == r_max[0])
                && (r_min[1] == r_max[1]) && (r_min[2] == r_max[2]);
            n_out.rgb_near_equal   = any && r_gray;
            n_out.last             = (r_ch == 3'd4);
        end
    end

    // memory address/write select
    always_comb begin
        mem_we = 1'b0;
        mem_addr = '0;
        mem_wdata = r_mem_q + CntW'(1);
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_addr = r_clr;
                mem_wdata = '0;
            end
            S_IDLE: mem_addr = {i_in_data.channel_select, i_in_data.bin_index};
            S_RD, S_WR: mem_addr = {r_ch, r_val[r_ch]};
            // keep the requested bin on the read port while the result waits
            S_BIN: mem_addr = {r_item.channel_select, r_item.bin_index};
            S_DIV, S_OUT, S_STR: mem_addr = '0;
            default: mem_addr = '0;
        endcase
        if (r_state == S_WR) mem_we = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == 11'd1279) n_state = S_IDLE;
            S_IDLE: if (accept) begin
                case (i_in_data.mode)
                    MODE_PIXEL:  n_state = S_STR;
                    MODE_FINISH: n_state = S_DIV;
                    MODE_READ:   n_state = S_BIN;
                    default:     n_state = S_CLR;
                endcase
            end
            S_STR:  n_state = (r_pix >= r_size) ? S_IDLE : S_RD;
            S_RD:   n_state = S_WR;
            S_WR:   n_state = (r_ch == 3'd4) ? S_IDLE : S_RD;
            S_DIV:  if (r_dcnt == 6'd0) n_state = S_OUT;
            S_OUT:  if (!r_out_v || !i_out_stall)
                        n_state = (r_ch == 3'd4) ? S_IDLE : S_DIV;
            S_BIN:  if (!r_out_v || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [8:0] rg, rb;
    assign rg = {1'b0, r_item.red} - {1'b0, r_item.green};
    assign rb = {1'b0, r_item.red} - {1'b0, r_item.blue};
    logic gray_ok;
    assign gray_ok = ((rg[8] ? -rg : rg) <= 9'(GrayTolerance))
                  && ((rb[8] ? -rb : rb) <= 9'(GrayTolerance));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_out_v <= 1'b0;
            r_pix   <= '0;
            r_cnt_dn <= '0;
            r_gray  <= 1'b1;
            r_ch    <= '0;
            r_dcnt  <= '0;
            for (int c = 0; c < NumChan; c++) begin
                r_min[c] <= 8'hFF;
                r_max[c] <= '0;
                r_sum[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            if (out_load) r_out <= n_out;
            unique case (r_state)
                S_CLR: r_clr <= r_clr + 11'd1;
                S_IDLE: if (accept) begin
                    r_item <= i_in_data;
                    r_ch   <= '0;
                    r_clr  <= '0;
                    r_luma <= 8'((32'd13933 * i_in_data.red + 32'd46871 * i_in_data.green
                               + 32'd4732 * i_in_data.blue + 32'd32768) >> 16);
                    if (i_in_data.mode == MODE_FINISH) begin
                        r_num  <= {1'b0, r_sum[0], 8'd0};
                        r_den  <= 26'(r_pix);
                        r_rem  <= '0;
                        r_dcnt <= 6'd41;
                    end else if (i_in_data.mode == MODE_CLEAR) begin
                        r_pix <= '0;
                        r_cnt_dn <= '0;
                        r_gray <= 1'b1;
                        for (int c = 0; c < NumChan; c++) begin
                            r_min[c] <= 8'hFF;
                            r_max[c] <= '0;
                            r_sum[c] <= '0;
                        end
                    end
                end
                S_STR: begin
                    r_stride <= (stride_q == '0) ? 26'd1 : 26'(stride_q);
                    r_val[0] <= r_item.red;
                    r_val[1] <= r_item.green;
                    r_val[2] <= r_item.blue;
                    r_val[3] <= r_item.alpha;
                    r_val[4] <= r_luma;
                end
                S_DIV: if (r_dcnt != 6'd0) begin
                    r_dcnt <= r_dcnt - 6'd1;
                    if (!d_trial[26]) begin
                        r_rem <= d_trial[25:0];
                        r_num <= {r_num[39:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[24:0], r_num[40]};
                        r_num <= {r_num[39:0], 1'b0};
                    end
                end
                S_RD: ;
                S_WR: begin
                    if (r_val[r_ch] < r_min[r_ch]) r_min[r_ch] <= r_val[r_ch];
                    if (r_val[r_ch] > r_max[r_ch]) r_max[r_ch] <= r_val[r_ch];
                    r_sum[r_ch] <= r_sum[r_ch] + 32'(r_val[r_ch]);
                    r_ch <= r_ch + 3'd1;
                    if (r_ch == 3'd4) begin
                        r_pix <= r_pix + CntW'(1);
                        if (r_cnt_dn == '0) begin
                            if (!gray_ok) r_gray <= 1'b0;
                            r_cnt_dn <= CntW'(r_stride - 26'd1);
                        end else begin
                            r_cnt_dn <= r_cnt_dn - CntW'(1);
                        end
                    end
                end
                S_OUT: if (out_load) begin
                    if (r_ch != 3'd4) begin
                        r_num  <= {1'b0, r_sum[r_ch + 3'd1], 8'd0};
                        r_rem  <= '0;
                        r_dcnt <= 6'd41;
                    end
                    r_ch <= r_ch + 3'd1;
                end
                S_BIN: ;
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_out_v && i_out_stall, r_out_v && $stable(r_out))
    `ASSERT_IMPL(a_minmax, i_clk, i_rst_n, r_pix != '0, r_min[0] <= r_max[0])
endmodule
